// ===== rtl/i420ds_pkg.sv =====
// ============================================================================
// i420ds_pkg
// Shared widths, plane codes, register indexes and reset values for the
// I420 nearest-neighbor downscaler.
// ============================================================================
`default_nettype none

package i420ds_pkg;

  // Configuration register width and index width
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  // Default largest supported frame dimension
  localparam int MAX_DIM_DEF = 4096;

  // Stream payload widths
  localparam int PIX_W   = 8;
  localparam int PLANE_W = 2;

  typedef logic [PLANE_W-1:0]   plane_t;
  typedef logic [CFG_IDX_W-1:0] reg_idx_t;

  // Plane codes; PLANE_DONE means the frame is complete
  localparam plane_t PLANE_Y    = 2'd0;
  localparam plane_t PLANE_U    = 2'd1;
  localparam plane_t PLANE_V    = 2'd2;
  localparam plane_t PLANE_DONE = 2'd3;

  // Register indexes
  localparam reg_idx_t REG_SRC_WIDTH  = 2'd0;
  localparam reg_idx_t REG_SRC_HEIGHT = 2'd1;
  localparam reg_idx_t REG_DST_WIDTH  = 2'd2;
  localparam reg_idx_t REG_DST_HEIGHT = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 13'd1280;
  localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 13'd720;
  localparam logic [CFG_W-1:0] DST_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] DST_HEIGHT_RST = 13'd360;

endpackage

`default_nettype wire

// ===== rtl/i420_nearest_downscaler_core.sv =====
// ============================================================================
// i420_nearest_downscaler_core
// Nearest-neighbor downscaler for I420 frames streamed one byte at a time.
// ============================================================================
//
// Usage:
//   Input stream: in_tdata carries one source byte, in_tuser[0] marks the
//   first byte of a frame (Y plane, then U, then V, raster order). Output
//   stream: out_tdata is the kept byte, out_tuser its plane (0 Y, 1 U, 2 V),
//   out_tlast flags the last output byte of the V plane.
//   Config: cfg_we/cfg_index/cfg_wdata set source and target luma sizes;
//   write only while the stream is idle. Sizes are clamped to [2, MAX_DIM]
//   and the target is clamped to the source.
//   Throughput: one byte per clock unless a held result stalls the input.
//   A kept byte is loaded into the output register on its input transfer;
//   position counters and accumulators update in the same cycle, which sets that rate.
//   Bytes that are dropped produce no output transfer.
//   When out_tready is low with a result held, in_tready drops until the
//   result is taken. Reset (rst_n low, synchronous) empties the output
//   register, returns the frame position to the start of the Y plane and
//   loads the default 1280x720 -> 640x360 sizes.
//
`default_nettype none

module i420_nearest_downscaler_core #(
  parameter int MAX_DIM = i420ds_pkg::MAX_DIM_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [i420ds_pkg::PIX_W-1:0]    in_tdata,   // [7:0] pixel_byte
  input  wire logic [0:0]                      in_tuser,   // [0] frame_begin
  // Output stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [i420ds_pkg::PIX_W-1:0]         out_tdata,  // [7:0] scaled_byte
  output logic [i420ds_pkg::PLANE_W-1:0]       out_tuser,  // [1:0] plane_id
  output logic                                 out_tlast,  // frame_end
  // Configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [i420ds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [i420ds_pkg::CFG_W-1:0]    cfg_wdata
);

  import i420ds_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int ACC_W = DIM_W + 1;
  localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [ACC_W-1:0] acc_t;

  // Clamp a raw register value to [2, MAX_DIM]
  function automatic dim_t clamp_dim(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] vx;
    vx = CMP_W'(v);
    if (vx < CMP_W'(2)) begin
      return DIM_W'(2);
    end else if (vx > CMP_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(vx);
  endfunction

  // Configuration registers
  logic [CFG_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;

  // Frame position state
  plane_t plane_r, plane_nxt;
  dim_t   scol_r, scol_nxt, srow_r, srow_nxt;
  dim_t   ocol_r, ocol_nxt, orow_r, orow_nxt;
  acc_t   cacc_r, cacc_nxt, racc_r, racc_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   out_data_r;
  plane_t             out_plane_r;
  logic               out_last_r;

  // Working values
  logic   in_xfer, frame_begin, active, col_sel, row_sel, hit, last_hit;
  plane_t plane_cur;
  dim_t   scol_cur, srow_cur, ocol_cur, orow_cur, scol_inc, srow_inc;
  acc_t   cacc_cur, racc_cur, col_sum, row_sum;
  dim_t   sw_c, sh_c, dw_c, dh_c, dw_l, dh_l, sw, sh, dw, dh;

  // Handshake: accept whenever the output register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // Effective sizes for the current plane
  always_comb begin
    sw_c = clamp_dim(src_w_r);
    sh_c = clamp_dim(src_h_r);
    dw_c = clamp_dim(dst_w_r);
    dh_c = clamp_dim(dst_h_r);
    dw_l = (dw_c > sw_c) ? sw_c : dw_c;
    dh_l = (dh_c > sh_c) ? sh_c : dh_c;
    if (plane_cur == PLANE_Y) begin
      sw = sw_c;
      sh = sh_c;
      dw = dw_l;
      dh = dh_l;
    end else begin
      sw = sw_c >> 1;
      sh = sh_c >> 1;
      dw = dw_l >> 1;
      dh = dh_l >> 1;
    end
  end

  // Frame begin restarts the position before this byte is judged
  assign frame_begin = in_tuser[0];
  assign plane_cur   = frame_begin ? PLANE_Y : plane_r;
  assign scol_cur    = frame_begin ? '0 : scol_r;
  assign srow_cur    = frame_begin ? '0 : srow_r;
  assign ocol_cur    = frame_begin ? '0 : ocol_r;
  assign orow_cur    = frame_begin ? '0 : orow_r;
  assign cacc_cur    = frame_begin ? '0 : cacc_r;
  assign racc_cur    = frame_begin ? '0 : racc_r;

  // Selection tests
  assign active   = (plane_cur != PLANE_DONE);
  assign col_sel  = (ocol_cur < dw) && (cacc_cur < ACC_W'(dw));
  assign row_sel  = (orow_cur < dh) && (racc_cur < ACC_W'(dh));
  assign hit      = active && col_sel && row_sel;
  assign last_hit = (plane_cur == PLANE_V) && (orow_cur + DIM_W'(1) == dh) &&
                    (ocol_cur + DIM_W'(1) == dw);

  assign col_sum  = cacc_cur + (col_sel ? ACC_W'(sw) : '0);
  assign row_sum  = racc_cur + (row_sel ? ACC_W'(sh) : '0);
  assign scol_inc = scol_cur + DIM_W'(1);
  assign srow_inc = srow_cur + DIM_W'(1);

  // Next position
  always_comb begin
    plane_nxt = plane_cur;
    scol_nxt  = scol_cur;
    srow_nxt  = srow_cur;
    ocol_nxt  = ocol_cur;
    orow_nxt  = orow_cur;
    cacc_nxt  = cacc_cur;
    racc_nxt  = racc_cur;
    if (active) begin
      // column tracking
      if (ocol_cur < dw) begin
        ocol_nxt = ocol_cur + DIM_W'(col_sel);
        cacc_nxt = (col_sum >= ACC_W'(dw)) ? col_sum - ACC_W'(dw) : '0;
      end
      scol_nxt = scol_inc;
      // end of a source row
      if (scol_inc >= sw) begin
        scol_nxt = '0;
        ocol_nxt = '0;
        cacc_nxt = '0;
        if (orow_cur < dh) begin
          orow_nxt = orow_cur + DIM_W'(row_sel);
          racc_nxt = (row_sum >= ACC_W'(dh)) ? row_sum - ACC_W'(dh) : '0;
        end
        srow_nxt = srow_inc;
        // end of a plane
        if (srow_inc >= sh) begin
          srow_nxt  = '0;
          orow_nxt  = '0;
          racc_nxt  = '0;
          plane_nxt = plane_cur + PLANE_W'(1);
        end
      end
    end
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = hit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r     <= SRC_WIDTH_RST;
      src_h_r     <= SRC_HEIGHT_RST;
      dst_w_r     <= DST_WIDTH_RST;
      dst_h_r     <= DST_HEIGHT_RST;
      plane_r     <= PLANE_Y;
      scol_r      <= '0;
      srow_r      <= '0;
      ocol_r      <= '0;
      orow_r      <= '0;
      cacc_r      <= '0;
      racc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH:  src_w_r <= cfg_wdata;
          REG_SRC_HEIGHT: src_h_r <= cfg_wdata;
          REG_DST_WIDTH:  dst_w_r <= cfg_wdata;
          REG_DST_HEIGHT: dst_h_r <= cfg_wdata;
          default:        src_w_r <= src_w_r;
        endcase
      end
      if (in_xfer) begin
        plane_r <= plane_nxt;
        scol_r  <= scol_nxt;
        srow_r  <= srow_nxt;
        ocol_r  <= ocol_nxt;
        orow_r  <= orow_nxt;
        cacc_r  <= cacc_nxt;
        racc_r  <= racc_nxt;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_xfer && hit) begin
      out_data_r  <= in_tdata;
      out_plane_r <= plane_cur;
      out_last_r  <= last_hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_plane_r;
  assign out_tlast  = out_last_r;

  // Assertions
  a_out_plane_real: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_plane_r != PLANE_DONE))
    else $error("output transfer tagged with a finished-frame plane");

  a_last_on_v: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_plane_r == PLANE_V))
    else $error("frame end flagged outside the V plane");

  a_begin_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && frame_begin) |=> (plane_r == PLANE_Y))
    else $error("frame begin did not restart in the Y plane");

  a_counter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (scol_r < DIM_W'(MAX_DIM)) && (srow_r < DIM_W'(MAX_DIM)))
    else $error("source position counter ran past the largest frame size");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cacc_r < ACC_W'(2 * MAX_DIM)) && (racc_r < ACC_W'(2 * MAX_DIM)))
    else $error("scaling accumulator out of range");

endmodule

`default_nettype wire

// ===== dv/tb_i420_nearest_downscaler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i420_nearest_downscaler_core
// Self-checking bench for the I420 nearest-neighbor downscaler. Streams
// source frames byte by byte under many size settings and predicts which
// bytes survive, with their plane and the end-of-frame flag. Each output
// transfer is compared against the oldest prediction. Covered: clamped and
// extreme sizes, restarts mid-frame, bytes after frame end, size changes
// mid-frame, and random stalls on both streams.
// ----------------------------------------------------------------------------

module tb_i420_nearest_downscaler_core;
  import i420ds_pkg::*;

  localparam int RANDOM_ITEMS = 320;
  localparam int HOLD_CYCLES  = 200;
  localparam int MAX_DIM      = MAX_DIM_DEF;

  typedef logic [CFG_W-1:0] dim_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    plane_t           plane;
    logic             last;
  } scaled_t;

  // Predictor of the downscaler plus the queue of expected output bytes
  class downscale_scoreboard;
    dim_t        size_reg [4];
    plane_t      plane;
    logic [12:0] src_col, src_row, out_col, out_row;
    logic [24:0] col_acc, row_acc;
    scaled_t     expected_q [$];
    int          errors;
    int          checked;

    function new();
      size_reg[REG_SRC_WIDTH]  = SRC_WIDTH_RST;
      size_reg[REG_SRC_HEIGHT] = SRC_HEIGHT_RST;
      size_reg[REG_DST_WIDTH]  = DST_WIDTH_RST;
      size_reg[REG_DST_HEIGHT] = DST_HEIGHT_RST;
      plane   = PLANE_Y;
      errors  = 0;
      checked = 0;
      clear_position();
    endfunction

    function void clear_position();
      src_col = '0;
      src_row = '0;
      out_col = '0;
      out_row = '0;
      col_acc = '0;
      row_acc = '0;
    endfunction

    function dim_t clamp_dim(dim_t v);
      if (v < 2) return 13'd2;
      if (v > MAX_DIM) return dim_t'(MAX_DIM);
      return v;
    endfunction

    function void write_reg(reg_idx_t idx, dim_t v);
      size_reg[idx] = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Bytes in one complete source frame under the current sizes
    function int frame_bytes();
      int sw, sh;
      sw = int'(clamp_dim(size_reg[REG_SRC_WIDTH]));
      sh = int'(clamp_dim(size_reg[REG_SRC_HEIGHT]));
      return sw * sh + 2 * ((sw >> 1) * (sh >> 1));
    endfunction

    // Advance the frame position by one accepted byte; 0 if it was ignored
    function bit note_transfer(logic [PIX_W-1:0] pix, logic frame_begin);
      dim_t    sw, sh, dw, dh;
      logic    col_keep, row_keep;
      scaled_t item;
      if (frame_begin) begin
        plane = PLANE_Y;
        clear_position();
      end
      if (plane == PLANE_DONE) return 1'b0;

      sw = clamp_dim(size_reg[REG_SRC_WIDTH]);
      sh = clamp_dim(size_reg[REG_SRC_HEIGHT]);
      dw = clamp_dim(size_reg[REG_DST_WIDTH]);
      dh = clamp_dim(size_reg[REG_DST_HEIGHT]);
      if (dw > sw) dw = sw;
      if (dh > sh) dh = sh;
      if (plane != PLANE_Y) begin
        sw = sw >> 1;
        sh = sh >> 1;
        dw = dw >> 1;
        dh = dh >> 1;
      end

      col_keep = (out_col < dw) && (col_acc < dw);
      row_keep = (out_row < dh) && (row_acc < dh);
      if (col_keep && row_keep) begin
        item.pix   = pix;
        item.plane = plane;
        item.last  = (plane == PLANE_V) && (out_row + 13'd1 == dh) &&
                     (out_col + 13'd1 == dw);
        expected_q.push_back(item);
      end

      // column stepping
      if (out_col < dw) begin
        if (col_keep) begin
          col_acc = col_acc + sw;
          out_col = out_col + 13'd1;
        end
        col_acc = (col_acc >= dw) ? col_acc - dw : '0;
      end
      src_col = src_col + 13'd1;

      // end of a source row, then end of a plane
      if (src_col >= sw) begin
        src_col = '0;
        out_col = '0;
        col_acc = '0;
        if (out_row < dh) begin
          if (row_keep) begin
            row_acc = row_acc + sh;
            out_row = out_row + 13'd1;
          end
          row_acc = (row_acc >= dh) ? row_acc - dh : '0;
        end
        src_row = src_row + 13'd1;
        if (src_row >= sh) begin
          clear_position();
          plane = plane + plane_t'(1);
        end
      end
      return 1'b1;
    endfunction

    function void check_result(logic [PIX_W-1:0] pix, plane_t pl, logic last);
      scaled_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected output transfer: byte %02h plane %0d last %0b",
                 $time, pix, pl, last);
        return;
      end
      want = expected_q.pop_front();
      if (want.pix !== pix) begin
        errors++;
        $display("%0t ns: scaled_byte expected %02h, actual %02h", $time, want.pix, pix);
      end
      if (want.plane !== pl) begin
        errors++;
        $display("%0t ns: plane_id expected %0d, actual %0d", $time, want.plane, pl);
      end
      if (want.last !== last) begin
        errors++;
        $display("%0t ns: frame_end expected %0b, actual %0b", $time, want.last, last);
      end
    endfunction
  endclass

  // DUT signals
  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [PIX_W-1:0]   in_tdata   = '0;
  logic [0:0]         in_tuser   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [PIX_W-1:0]   out_tdata;
  plane_t             out_tuser;
  logic               out_tlast;
  logic               cfg_we     = 1'b0;
  reg_idx_t           cfg_index  = '0;
  dim_t               cfg_wdata  = '0;

  downscale_scoreboard sb;
  bit steady_flow = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_on     = 1'b0;
  int n_transfers = 0;
  int n_live      = 0;
  int n_settings  = 0;

  i420_nearest_downscaler_core #(
    .MAX_DIM(MAX_DIM)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [7:0] pixel_byte
    .in_tuser  (in_tuser),   // [0] frame_begin
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [7:0] scaled_byte
    .out_tuser (out_tuser),  // [1:0] plane_id
    .out_tlast (out_tlast),  // frame_end
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle lengths: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Size register value: sometimes below the clamp, else in [2, hi]
  function automatic dim_t pick_dim(int hi);
    if ($urandom_range(0, 9) == 0) return dim_t'($urandom_range(0, 1));
    return dim_t'($urandom_range(2, hi));
  endfunction

  // Output ready pattern, with one long hold-off on request
  initial begin : rx_ready
    int stall;
    forever begin
      if (hold_req) begin
        hold_on = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on  = 1'b0;
        hold_req = 1'b0;
      end else if (steady_flow) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = gap_len();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  // One input transfer
  task automatic send_byte(input logic [PIX_W-1:0] pix, input logic frame_begin);
    int gap;
    gap = steady_flow ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= frame_begin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_transfers++;
    if (sb.note_transfer(pix, frame_begin)) n_live++;
  endtask

  // Random bytes without frame start, or with an occasional one
  task automatic send_run(input int n, input bit with_starts);
    for (int i = 0; i < n; i++) begin
      send_byte(PIX_W'($urandom), with_starts && ($urandom_range(0, 15) == 0));
    end
  endtask

  // A frame from its first byte; cut > 0 stops it early
  task automatic send_frame(input int cut);
    int n;
    n = sb.frame_bytes();
    if (cut > 0 && cut < n) n = cut;
    send_byte(PIX_W'($urandom), 1'b1);
    for (int i = 1; i < n; i++) send_byte(PIX_W'($urandom), 1'b0);
  endtask

  // Sender pause until every expected byte has come out
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input dim_t v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic program_sizes(input dim_t sw, input dim_t sh, input dim_t dw, input dim_t dh);
    drain_outputs();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Stimulus
  initial begin : stim
    int   r, phase, live_mark;
    dim_t sw, sh;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default 1280x720 -> 640x360: first bytes, extreme values, restart mid-frame
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);

    // Sizes below and above the clamp; the frame is resumed under them
    program_sizes(13'd0, 13'd1, 13'h1FFF, 13'h1FFF);
    send_run(3, 1'b0);
    send_frame(0);
    send_run(3, 1'b0);
    send_byte(8'hC3, 1'b1);
    send_run(5, 1'b0);

    // Widest source, smallest target: rare results, largest accumulator steps
    steady_flow = 1'b1;
    program_sizes(13'h1FFF, 13'd2, 13'd0, 13'd1);
    send_frame(80);
    // Tallest source kept whole: every byte passes
    program_sizes(13'd2, 13'h1FFF, 13'd2, 13'd4096);
    send_frame(80);
    program_sizes(13'd4096, 13'd2, 13'd4096, 13'd2);
    send_frame(40);
    steady_flow = 1'b0;

    // Random sizes and frames, with broken frames and noise mixed in
    phase = 0;
    live_mark = n_live;
    while (n_live - live_mark < RANDOM_ITEMS) begin
      sw = pick_dim(12);
      sh = pick_dim(12);
      program_sizes(sw, sh, pick_dim((sw < 2 ? 2 : sw) + 2),
                    pick_dim((sh < 2 ? 2 : sh) + 2));
      steady_flow = ($urandom_range(0, 4) == 0);
      if (phase == 0) begin
        // long receiver hold-off while bytes keep coming
        steady_flow = 1'b0;
        hold_req = 1'b1;
        wait (hold_on);
        send_run(12, 1'b0);
      end
      // continue a frame left open before the size change
      if ($urandom_range(0, 3) == 0) send_run($urandom_range(1, 6), 1'b0);
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_frame(0);
          if ($urandom_range(0, 2) == 0) send_run($urandom_range(1, 4), 1'b0);
        end else if (r < 88) begin
          send_frame($urandom_range(1, 20));
        end else begin
          send_run($urandom_range(1, 8), 1'b1);
        end
      end
      phase++;
    end
    steady_flow = 1'b0;

    drain_outputs();
    repeat (20) @(posedge clk);
    $display("Streamed %0d input transfers (%0d inside frames) under %0d size settings,",
             n_transfers, n_live, n_settings);
    $display("checked %0d output transfers, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("i420_nearest_downscaler_core regression: pass");
    end else begin
      $display("i420_nearest_downscaler_core regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Timeout waiting on the stream handshakes.");
    $display("i420_nearest_downscaler_core regression: fail");
    $finish;
  end

endmodule
